// ----- rtl/cpd_pkg.sv -----
// Shared types and constants for the command packet deframer.
// No dependencies; imported by every module of the block.
package cpd_pkg;

   localparam int unsigned ByteWidth   = 8;
   localparam int unsigned CsrIdxWidth = 3;

   typedef logic [ByteWidth-1:0] byte_type;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_HEADER  = 3'd0,
      CSR_QUERY   = 3'd1,
      CSR_CONTROL = 3'd2,
      CSR_OPEN    = 3'd3,
      CSR_CLOSE   = 3'd4
   } csr_idx_type;

   typedef enum logic [2:0] {
      STEP_HEADER   = 3'd0,
      STEP_ID       = 3'd1,
      STEP_LENGTH   = 3'd2,
      STEP_COMMAND  = 3'd3,
      STEP_DATA     = 3'd4,
      STEP_CHECKSUM = 3'd5
   } step_type;

   typedef enum logic [1:0] {
      CHARGE_NONE  = 2'd0,
      CHARGE_OPEN  = 2'd1,
      CHARGE_CLOSE = 2'd2
   } charge_type;

   typedef struct packed {
      byte_type header_code;
      byte_type query_code;
      byte_type control_code;
      byte_type open_code;
      byte_type close_code;
   } cfg_type;

   typedef struct packed {
      logic       packet_done;
      logic       checksum_ok;
      logic       query_request;
      byte_type   packet_id;
      logic [1:0] charge_command;
   } rsp_type;

endpackage

// ----- rtl/command_packet_deframer_top.sv -----
// Command packet deframer top level: config registers, parser, result register.
// Depends on cpd_pkg, cpd_csr, cpd_parser and cpd_out.
//
//   channel | ports                                  | handshake
//   --------+----------------------------------------+-------------------
//   req     | req_rx_byte                            | req_valid/req_ready
//   rsp     | rsp_packet_done .. rsp_charge_command  | rsp_valid/rsp_ready
//   csr     | csr_index, csr_wdata                   | csr_wr_en, no wait
//
// One word per cycle while req_ready is high; each word's result appears in the cycle after acceptance.
// The parse state updates in the same edge that accepts the word.
// req_ready is low only while a result waits and rsp_ready is low.
// Synchronous reset clears parse state, codes and the result valid.
module command_packet_deframer_top
   import cpd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_rx_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_packet_done,
   output logic                   rsp_checksum_ok,
   output logic                   rsp_query_request,
   output logic [7:0]             rsp_packet_id,
   output logic [1:0]             rsp_charge_command,
   input  logic                   csr_wr_en,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [7:0]             csr_wdata
);

   cfg_type cfg;
   rsp_type rsp_next;
   rsp_type rsp_q;
   logic    fire;
   logic    can_load;

   assign req_ready = can_load;
   assign fire      = req_valid && can_load;

   cpd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   cpd_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .fire    (fire),
      .rx_byte (req_rx_byte),
      .rsp     (rsp_next)
   );

   cpd_out u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (fire),
      .rsp_data  (rsp_next),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .can_load  (can_load),
      .rsp_q     (rsp_q)
   );

   assign rsp_packet_done    = rsp_q.packet_done;
   assign rsp_checksum_ok    = rsp_q.checksum_ok;
   assign rsp_query_request  = rsp_q.query_request;
   assign rsp_packet_id      = rsp_q.packet_id;
   assign rsp_charge_command = rsp_q.charge_command;

endmodule

// ----- rtl/cpd_csr.sv -----
// Configuration register file: five byte-wide codes, write only.
// Depends on cpd_pkg.
module cpd_csr
   import cpd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  byte_type               csr_wdata,
   output cfg_type                cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_HEADER:  cfg_in.header_code  = csr_wdata;
            CSR_QUERY:   cfg_in.query_code   = csr_wdata;
            CSR_CONTROL: cfg_in.control_code = csr_wdata;
            CSR_OPEN:    cfg_in.open_code    = csr_wdata;
            CSR_CLOSE:   cfg_in.close_code   = csr_wdata;
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/cpd_parser.sv -----
// Packet parse state and per-word result logic.
// Depends on cpd_pkg; state advances on each accepted word.
module cpd_parser
   import cpd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     fire,
   input  byte_type rx_byte,
   output rsp_type  rsp
);

   logic [2:0] step_ff, step_in;
   byte_type   id_ff, id_in;
   byte_type   len_ff, len_in;
   byte_type   cmd_ff, cmd_in;
   byte_type   sum_ff, sum_in;
   byte_type   count_ff, count_in;
   byte_type   first_ff, first_in;
   logic [1:0] charge_ff, charge_in;
   byte_type   count_inc;
   logic       sum_match;

   assign count_inc = count_ff + 8'd1;
   assign sum_match = (sum_ff == rx_byte);

   // next step
   always_comb begin
      step_in = step_ff;
      if (fire) begin
         case (step_ff)
            STEP_HEADER:   step_in = (rx_byte == cfg.header_code) ? STEP_ID : STEP_HEADER;
            STEP_ID:       step_in = STEP_LENGTH;
            STEP_LENGTH:   step_in = STEP_COMMAND;
            STEP_COMMAND:  step_in = (len_ff <= 8'd1) ? STEP_CHECKSUM : STEP_DATA;
            STEP_DATA:     step_in = (count_inc >= len_ff) ? STEP_CHECKSUM : STEP_DATA;
            STEP_CHECKSUM: step_in = STEP_HEADER;
            default:       step_in = STEP_HEADER;
         endcase
      end
   end

   // datapath and result
   always_comb begin
      id_in     = id_ff;
      len_in    = len_ff;
      cmd_in    = cmd_ff;
      sum_in    = sum_ff;
      count_in  = count_ff;
      first_in  = first_ff;
      charge_in = charge_ff;
      rsp       = '0;
      case (step_ff)
         STEP_ID:     id_in  = rx_byte;
         STEP_LENGTH: len_in = rx_byte;
         STEP_COMMAND: begin
            cmd_in   = rx_byte;
            sum_in   = rx_byte;
            count_in = 8'd1;
         end
         STEP_DATA: begin
            if (count_ff == 8'd1) begin
               first_in = rx_byte;
            end
            sum_in   = sum_ff + rx_byte;
            count_in = count_inc;
         end
         STEP_CHECKSUM: begin
            rsp.packet_done = 1'b1;
            if (sum_match) begin
               rsp.checksum_ok = 1'b1;
               if (cmd_ff == cfg.query_code) begin
                  rsp.query_request = 1'b1;
               end else if (cmd_ff == cfg.control_code && len_ff > 8'd1) begin
                  if (first_ff == cfg.open_code) begin
                     charge_in = CHARGE_OPEN;
                  end else if (first_ff == cfg.close_code) begin
                     charge_in = CHARGE_CLOSE;
                  end
               end
            end
            sum_in   = '0;
            count_in = '0;
         end
         default: ;
      endcase
      rsp.packet_id      = id_in;
      rsp.charge_command = charge_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff   <= STEP_HEADER;
         id_ff     <= '0;
         len_ff    <= '0;
         cmd_ff    <= '0;
         sum_ff    <= '0;
         count_ff  <= '0;
         first_ff  <= '0;
         charge_ff <= CHARGE_NONE;
      end else if (fire) begin
         step_ff   <= step_in;
         id_ff     <= id_in;
         len_ff    <= len_in;
         cmd_ff    <= cmd_in;
         sum_ff    <= sum_in;
         count_ff  <= count_in;
         first_ff  <= first_in;
         charge_ff <= charge_in;
      end
   end

   a_checksum_ends: assert property (@(posedge clock) disable iff (reset)
      fire && step_ff == STEP_CHECKSUM |=> step_ff == STEP_HEADER && sum_ff == '0)
      else $error("parser did not return to header after checksum word");

   a_short_length: assert property (@(posedge clock) disable iff (reset)
      fire && step_ff == STEP_COMMAND && len_ff <= 8'd1 |=> step_ff == STEP_CHECKSUM)
      else $error("short length did not skip to checksum");

   a_charge_held: assert property (@(posedge clock) disable iff (reset)
      !(fire && step_ff == STEP_CHECKSUM) |=> $stable(charge_ff))
      else $error("charge request changed outside a checksum word");

   a_charge_code: assert property (@(posedge clock) disable iff (reset)
      charge_ff != 2'd3)
      else $error("invalid charge request code");

endmodule

// ----- rtl/cpd_out.sv -----
// Result register with valid; frees the input side when no result waits or rsp_ready is high.
// Depends on cpd_pkg.
module cpd_out
   import cpd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    load,
   input  rsp_type rsp_data,
   input  logic    rsp_ready,
   output logic    rsp_valid,
   output logic    can_load,
   output rsp_type rsp_q
);

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   assign can_load = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= rsp_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_q     = data_ff;

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      load |=> valid_ff)
      else $error("loaded result not presented");

   a_ok_needs_done: assert property (@(posedge clock) disable iff (reset)
      valid_ff && data_ff.checksum_ok |-> data_ff.packet_done)
      else $error("checksum_ok without packet_done");

endmodule
